@@ src/sba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab buffer allocator package
// Sizes, row layout, status codes and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int NUM_FRAMES   = 64;
  localparam int CHUNK_BYTES  = 4096;
  localparam int NUM_CLASSES  = 6;
  localparam int HEADER_BYTES = 20;
  localparam int NREGS        = 6;

  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int PTR_W   = FRAME_W + 1;
  localparam int OFF_W   = $clog2(CHUNK_BYTES);
  localparam int SIZE_W  = 13;
  localparam int CNT_W   = 10;
  localparam int CLS_W   = 3;
  localparam int ADDR_W  = 18;
  localparam int LINK_AW = FRAME_W + OFF_W - 2;
  localparam int LINK_DEPTH = NUM_FRAMES * (CHUNK_BYTES / 4);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_FRAMES);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam int SZ0 = 8;
  localparam int SZ1 = 16;
  localparam int SZ2 = 32;
  localparam int SZ3 = 64;
  localparam int SZ4 = 128;
  localparam int SZ5 = 4096;

  localparam int CAP0 = (SZ0 < 4 || SZ0 >= CHUNK_BYTES || CHUNK_BYTES - SZ0 < HEADER_BYTES)
                        ? 0 : (CHUNK_BYTES - SZ0 - HEADER_BYTES) / SZ0 + 1;
  localparam int CAP1 = (SZ1 < 4 || SZ1 >= CHUNK_BYTES || CHUNK_BYTES - SZ1 < HEADER_BYTES)
                        ? 0 : (CHUNK_BYTES - SZ1 - HEADER_BYTES) / SZ1 + 1;
  localparam int CAP2 = (SZ2 < 4 || SZ2 >= CHUNK_BYTES || CHUNK_BYTES - SZ2 < HEADER_BYTES)
                        ? 0 : (CHUNK_BYTES - SZ2 - HEADER_BYTES) / SZ2 + 1;
  localparam int CAP3 = (SZ3 < 4 || SZ3 >= CHUNK_BYTES || CHUNK_BYTES - SZ3 < HEADER_BYTES)
                        ? 0 : (CHUNK_BYTES - SZ3 - HEADER_BYTES) / SZ3 + 1;
  localparam int CAP4 = (SZ4 < 4 || SZ4 >= CHUNK_BYTES || CHUNK_BYTES - SZ4 < HEADER_BYTES)
                        ? 0 : (CHUNK_BYTES - SZ4 - HEADER_BYTES) / SZ4 + 1;
  localparam int CAP5 = (SZ5 < 4 || SZ5 >= CHUNK_BYTES || CHUNK_BYTES - SZ5 < HEADER_BYTES)
                        ? 0 : (CHUNK_BYTES - SZ5 - HEADER_BYTES) / SZ5 + 1;

  localparam logic [SIZE_W-1:0] SIZE_RST [NREGS] = '{
    SIZE_W'(SZ0), SIZE_W'(SZ1), SIZE_W'(SZ2), SIZE_W'(SZ3), SIZE_W'(SZ4), SIZE_W'(SZ5)
  };
  localparam logic [CNT_W-1:0] CAP_RST [NREGS] = '{
    CNT_W'(CAP0), CNT_W'(CAP1), CNT_W'(CAP2), CNT_W'(CAP3), CNT_W'(CAP4), CNT_W'(CAP5)
  };

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [CNT_W-1:0] cnt;
    logic [OFF_W-1:0] head;
    logic [PTR_W-1:0] nxt;
    logic [PTR_W-1:0] prv;
  } frame_row_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LARGE    = 3'd1,
    ST_ILLEGAL  = 3'd2,
    ST_NO_FRAME = 3'd3,
    ST_BAD_FREE = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CFG,
    S_DECODE,
    S_POP,
    S_LAYOUT,
    S_NEW_WR,
    S_A_RD,
    S_A_LINK,
    S_F_RD,
    S_F_MUL,
    S_F_DIV,
    S_F_CHK,
    S_FIX_ARD,
    S_FIX_AWR,
    S_FIX_BRD,
    S_FIX_BWR,
    S_OUT
  } state_t;

endpackage

@@ src/sba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab buffer allocator RAM
// Simple dual-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module sba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/sba_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab buffer allocator divider
// Restoring divider, one quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module sba_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sba_pkg::SIZE_W-1:0] dividend,
  input  logic [sba_pkg::SIZE_W-1:0] divisor,
  output logic                      done,
  output logic [sba_pkg::SIZE_W-1:0] quot,
  output logic [sba_pkg::SIZE_W-1:0] rem
);
  import sba_pkg::*;

  localparam int CW = $clog2(SIZE_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] quo_r, quo_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dvs_r, dvs_nxt;
  logic [SIZE_W:0]   r_sh;
  logic [SIZE_W:0]   r_new;
  logic              ge;

  always_comb begin
    r_sh     = {rem_r, quo_r[SIZE_W-1]};
    ge       = (r_sh >= {1'b0, dvs_r});
    r_new    = ge ? (r_sh - {1'b0, dvs_r}) : r_sh;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(SIZE_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SIZE_W-2:0], ge};
      rem_nxt = r_new[SIZE_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

@@ src/slab_buffer_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab buffer allocator
// Size-class slab allocator over a pool of frames, state kept in RAMs.
// ----------------------------------------------------------------------------
// Alloc from a partial frame reads the head row, takes its link and relinks neighbors when the frame fills.
// Alloc of a fresh frame pops the frame stack and walks the layout, writing one link per slot.
// Free checks the offset with the bit-serial divider.
// After S_OUT registers the result, the next beat is taken in S_IDLE once no class size write is pending.
// A class size write holds off beats while its capacity is recomputed.
// Synchronous active-low reset restores sizes, lists and the frame stack at once.
// ----------------------------------------------------------------------------
module slab_buffer_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // req_type
  input  logic [31:0] in_tdata,   // request_size, buffer_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // status
  output logic [23:0] out_tdata,  // granted_address, frame_released
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [12:0] cfg_data
);
  import sba_pkg::*;

  state_t            state_r, state_nxt;
  logic              req_r, req_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic [FRAME_W-1:0] frm_r, frm_nxt;
  frame_row_t        row_r, row_nxt;
  logic [SIZE_W-1:0] csz_r, csz_nxt;
  logic [CNT_W-1:0]  capv_r, capv_nxt;
  logic [SIZE_W-1:0] prod_r, prod_nxt;
  logic [OFF_W-1:0]  start_r, start_nxt;
  logic [SIZE_W-1:0] off_r, off_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  status_t           status_r, status_nxt;
  logic [ADDR_W-1:0] grant_r, grant_nxt;
  logic              rel_r, rel_nxt;
  logic              fa_en_r, fa_en_nxt;
  logic [PTR_W-1:0]  fa_idx_r, fa_idx_nxt;
  logic [PTR_W-1:0]  fa_val_r, fa_val_nxt;
  logic              fb_en_r, fb_en_nxt;
  logic [PTR_W-1:0]  fb_idx_r, fb_idx_nxt;
  logic [PTR_W-1:0]  fb_val_r, fb_val_nxt;
  logic [PTR_W-1:0]  stk_cnt_r, stk_cnt_nxt;
  logic [NUM_FRAMES-1:0] in_use_r, in_use_nxt;
  logic [NUM_FRAMES-1:0] stk_vld_r, stk_vld_nxt;
  logic [SIZE_W-1:0] csize_r [NREGS];
  logic [SIZE_W-1:0] csize_nxt [NREGS];
  logic [CNT_W-1:0]  cap_r [NREGS];
  logic [CNT_W-1:0]  cap_nxt [NREGS];
  logic [PTR_W-1:0]  head_r [NREGS];
  logic [PTR_W-1:0]  head_nxt [NREGS];
  logic [NREGS-1:0]  dirty_r, dirty_nxt;
  logic [CLS_W-1:0]  dcls_r, dcls_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_grant_r, out_grant_nxt;
  logic              out_rel_r, out_rel_nxt;

  logic              fm_we;
  logic [FRAME_W-1:0] fm_waddr, fm_raddr;
  frame_row_t        fm_wdata, fm_rdata;
  logic              st_we;
  logic [FRAME_W-1:0] st_waddr, st_raddr;
  logic [FRAME_W-1:0] st_wdata, st_rdata;
  logic              lk_we;
  logic [LINK_AW-1:0] lk_waddr, lk_raddr;
  logic [OFF_W-1:0]  lk_wdata, lk_rdata;
  logic              div_start, div_done;
  logic [SIZE_W-1:0] div_dividend, div_divisor, div_q, div_rem;

  sba_ram #(.WIDTH($bits(frame_row_t)), .DEPTH(NUM_FRAMES)) u_frame_ram (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(fm_raddr), .rdata(fm_rdata)
  );

  sba_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_stack_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  sba_ram #(.WIDTH(OFF_W), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  sba_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quot(div_q), .rem(div_rem)
  );

  always_comb begin
    logic                  lf;
    logic [CLS_W-1:0]      lc;
    logic                  pf;
    logic [CLS_W-1:0]      pick;
    logic [SIZE_W-1:0]     psz;
    logic [CLS_W-1:0]      fc;
    logic [CNT_W-1:0]      mul_a;
    logic [SIZE_W-1:0]     mul_b;
    logic [CNT_W+SIZE_W-1:0] mul_full;
    logic [SIZE_W-1:0]     start_full;
    logic [OFF_W-1:0]      off_in;
    logic [OFF_W-1:0]      off_diff;
    logic [PTR_W-1:0]      stk_dec;
    logic [FRAME_W-1:0]    sidx;
    logic [SIZE_W-1:0]     off_step;
    logic [CNT_W:0]        k_inc;
    logic [CNT_W:0]        cnt_inc;
    logic [CNT_W-1:0]      cnt_dec;
    logic [OFF_W:0]        head_step;
    frame_row_t            w;

    state_nxt      = state_r;
    req_nxt        = req_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    cls_nxt        = cls_r;
    frm_nxt        = frm_r;
    row_nxt        = row_r;
    csz_nxt        = csz_r;
    capv_nxt       = capv_r;
    prod_nxt       = prod_r;
    start_nxt      = start_r;
    off_nxt        = off_r;
    k_nxt          = k_r;
    status_nxt     = status_r;
    grant_nxt      = grant_r;
    rel_nxt        = rel_r;
    fa_en_nxt      = fa_en_r;
    fa_idx_nxt     = fa_idx_r;
    fa_val_nxt     = fa_val_r;
    fb_en_nxt      = fb_en_r;
    fb_idx_nxt     = fb_idx_r;
    fb_val_nxt     = fb_val_r;
    stk_cnt_nxt    = stk_cnt_r;
    in_use_nxt     = in_use_r;
    stk_vld_nxt    = stk_vld_r;
    csize_nxt      = csize_r;
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    dirty_nxt      = dirty_r;
    dcls_nxt       = dcls_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    out_rel_nxt    = out_rel_r;

    in_tready    = 1'b0;
    fm_we        = 1'b0;
    fm_waddr     = frm_r;
    fm_wdata     = row_r;
    fm_raddr     = frm_r;
    st_we        = 1'b0;
    st_waddr     = stk_cnt_r[FRAME_W-1:0];
    st_wdata     = frm_r;
    st_raddr     = stk_cnt_r[FRAME_W-1:0];
    lk_we        = 1'b0;
    lk_waddr     = {frm_r, off_r[OFF_W-1:2]};
    lk_wdata     = '0;
    lk_raddr     = {frm_r, row_r.head[OFF_W-1:2]};
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = csz_r;
    w            = row_r;

    lf = 1'b0;
    lc = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (!lf && (csize_r[i] == '0 || csize_r[i] == size_r)) begin
        lf = 1'b1;
        lc = CLS_W'(i);
      end
    end

    pf   = 1'b0;
    pick = '0;
    for (int i = 0; i < NREGS; i++) begin
      if (!pf && dirty_r[i]) begin
        pf   = 1'b1;
        pick = CLS_W'(i);
      end
    end
    psz = csize_r[pick];

    fc = (fm_rdata.cls >= CLS_W'(NREGS)) ? (fm_rdata.cls - CLS_W'(NREGS)) : fm_rdata.cls;
    if (state_r == S_F_RD) begin
      mul_a = cap_r[fc];
      mul_b = csize_r[fc];
    end else begin
      mul_a = cap_r[lc];
      mul_b = csize_r[lc];
    end
    mul_full   = mul_a * mul_b;
    start_full = SIZE_W'(CHUNK_BYTES) - prod_r;
    off_in     = addr_r[OFF_W-1:0];
    off_diff   = off_in - start_full[OFF_W-1:0];
    stk_dec    = stk_cnt_r - PTR_W'(1);
    sidx       = stk_cnt_r[FRAME_W-1:0];
    off_step   = off_r + csz_r;
    k_inc      = {1'b0, k_r} + (CNT_W+1)'(1);
    cnt_inc    = {1'b0, row_r.cnt} + (CNT_W+1)'(1);
    cnt_dec    = (row_r.cnt != '0) ? (row_r.cnt - CNT_W'(1)) : '0;
    head_step  = {1'b0, start_r} + csz_r[OFF_W:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_tready = (dirty_r == '0) && !cfg_we;
        if (in_tvalid && in_tready) begin
          req_nxt    = in_tuser[0];
          size_nxt   = in_tdata[SIZE_W-1:0];
          addr_nxt   = in_tdata[SIZE_W+ADDR_W-1:SIZE_W];
          status_nxt = ST_OK;
          grant_nxt  = '0;
          rel_nxt    = 1'b0;
          fa_en_nxt  = 1'b0;
          fb_en_nxt  = 1'b0;
          state_nxt  = S_DECODE;
        end else if (pf) begin
          dirty_nxt[pick] = 1'b0;
          if (psz < SIZE_W'(4) || psz >= SIZE_W'(CHUNK_BYTES) ||
              psz > SIZE_W'(CHUNK_BYTES - HEADER_BYTES)) begin
            cap_nxt[pick] = '0;
          end else begin
            div_start    = 1'b1;
            div_dividend = SIZE_W'(CHUNK_BYTES - HEADER_BYTES) - psz;
            div_divisor  = psz;
            dcls_nxt     = pick;
            state_nxt    = S_CFG;
          end
        end
      end
      S_CFG: begin
        if (div_done) begin
          cap_nxt[dcls_r] = div_q[CNT_W-1:0] + CNT_W'(1);
          state_nxt       = S_IDLE;
        end
      end
      S_DECODE: begin
        if (req_r == REQ_ALLOC) begin
          if (size_r == '0 || !lf || csize_r[lc] == '0) begin
            status_nxt = ST_ILLEGAL;
            state_nxt  = S_OUT;
          end else if (size_r >= SIZE_W'(CHUNK_BYTES)) begin
            status_nxt = ST_LARGE;
            state_nxt  = S_OUT;
          end else if (cap_r[lc] == '0) begin
            status_nxt = ST_ILLEGAL;
            state_nxt  = S_OUT;
          end else begin
            cls_nxt  = lc;
            capv_nxt = cap_r[lc];
            csz_nxt  = csize_r[lc];
            prod_nxt = mul_full[SIZE_W-1:0];
            if (head_r[lc] >= NIL) begin
              if (stk_cnt_r == '0) begin
                status_nxt = ST_NO_FRAME;
                state_nxt  = S_OUT;
              end else begin
                stk_cnt_nxt = stk_dec;
                st_raddr    = stk_dec[FRAME_W-1:0];
                state_nxt   = S_POP;
              end
            end else begin
              frm_nxt   = head_r[lc][FRAME_W-1:0];
              fm_raddr  = head_r[lc][FRAME_W-1:0];
              state_nxt = S_A_RD;
            end
          end
        end else begin
          if (size_r >= SIZE_W'(CHUNK_BYTES)) begin
            status_nxt = ST_LARGE;
            state_nxt  = S_OUT;
          end else if (!in_use_r[addr_r[ADDR_W-1:OFF_W]]) begin
            status_nxt = ST_BAD_FREE;
            state_nxt  = S_OUT;
          end else begin
            frm_nxt   = addr_r[ADDR_W-1:OFF_W];
            fm_raddr  = addr_r[ADDR_W-1:OFF_W];
            state_nxt = S_F_RD;
          end
        end
      end
      S_POP: begin
        frm_nxt   = stk_vld_r[sidx] ? st_rdata : (FRAME_W'(NUM_FRAMES - 1) - sidx);
        start_nxt = start_full[OFF_W-1:0];
        off_nxt   = {{(SIZE_W-OFF_W){1'b0}}, start_full[OFF_W-1:0]};
        k_nxt     = '0;
        state_nxt = S_LAYOUT;
      end
      S_LAYOUT: begin
        lk_we    = 1'b1;
        lk_waddr = {frm_r, off_r[OFF_W-1:2]};
        lk_wdata = (k_inc >= {1'b0, capv_r}) ? '0 : off_step[OFF_W-1:0];
        off_nxt  = off_step;
        k_nxt    = k_inc[CNT_W-1:0];
        if (k_inc >= {1'b0, capv_r}) begin
          state_nxt = S_NEW_WR;
        end
      end
      S_NEW_WR: begin
        in_use_nxt[frm_r] = 1'b1;
        w.cls  = cls_r;
        w.cnt  = capv_r - CNT_W'(1);
        w.head = (capv_r > CNT_W'(1)) ? head_step[OFF_W-1:0] : '0;
        w.nxt  = NIL;
        w.prv  = NIL;
        fm_we    = 1'b1;
        fm_waddr = frm_r;
        fm_wdata = w;
        if (capv_r > CNT_W'(1)) begin
          head_nxt[cls_r] = {1'b0, frm_r};
        end
        grant_nxt  = {frm_r, start_r};
        status_nxt = ST_OK;
        state_nxt  = S_OUT;
      end
      S_A_RD: begin
        row_nxt   = fm_rdata;
        lk_raddr  = {frm_r, fm_rdata.head[OFF_W-1:2]};
        state_nxt = S_A_LINK;
      end
      S_A_LINK: begin
        w.cnt    = cnt_dec;
        w.head   = lk_rdata;
        fm_we    = 1'b1;
        fm_waddr = frm_r;
        fm_wdata = w;
        grant_nxt  = {frm_r, row_r.head};
        status_nxt = ST_OK;
        if (cnt_dec == '0) begin
          fa_en_nxt  = (row_r.nxt < NIL);
          fa_idx_nxt = row_r.nxt;
          fa_val_nxt = row_r.prv;
          fb_en_nxt  = (row_r.prv < NIL);
          fb_idx_nxt = row_r.prv;
          fb_val_nxt = row_r.nxt;
          if (row_r.prv >= NIL) begin
            head_nxt[cls_r] = row_r.nxt;
          end
        end
        state_nxt = S_FIX_ARD;
      end
      S_F_RD: begin
        row_nxt = fm_rdata;
        cls_nxt = fc;
        if (cap_r[fc] == '0 || csize_r[fc] == '0) begin
          status_nxt = ST_BAD_FREE;
          state_nxt  = S_OUT;
        end else begin
          capv_nxt  = cap_r[fc];
          csz_nxt   = csize_r[fc];
          prod_nxt  = mul_full[SIZE_W-1:0];
          state_nxt = S_F_MUL;
        end
      end
      S_F_MUL: begin
        start_nxt = start_full[OFF_W-1:0];
        if ({{(SIZE_W-OFF_W){1'b0}}, off_in} < start_full) begin
          status_nxt = ST_BAD_FREE;
          state_nxt  = S_OUT;
        end else begin
          div_start    = 1'b1;
          div_dividend = {{(SIZE_W-OFF_W){1'b0}}, off_diff};
          div_divisor  = csz_r;
          state_nxt    = S_F_DIV;
        end
      end
      S_F_DIV: begin
        if (div_done) begin
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (div_rem != '0 || row_r.cnt >= capv_r) begin
          status_nxt = ST_BAD_FREE;
          state_nxt  = S_OUT;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = {frm_r, off_in[OFF_W-1:2]};
          lk_wdata = row_r.head;
          w.head   = off_in;
          w.cnt    = cnt_inc[CNT_W-1:0];
          if (cnt_inc == {1'b0, capv_r}) begin
            if (row_r.cnt != '0) begin
              fa_en_nxt  = (row_r.nxt < NIL);
              fa_idx_nxt = row_r.nxt;
              fa_val_nxt = row_r.prv;
              fb_en_nxt  = (row_r.prv < NIL);
              fb_idx_nxt = row_r.prv;
              fb_val_nxt = row_r.nxt;
              if (row_r.prv >= NIL) begin
                head_nxt[cls_r] = row_r.nxt;
              end
            end
            in_use_nxt[frm_r] = 1'b0;
            if (stk_cnt_r < PTR_W'(NUM_FRAMES)) begin
              st_we             = 1'b1;
              st_waddr          = sidx;
              st_wdata          = frm_r;
              stk_vld_nxt[sidx] = 1'b1;
              stk_cnt_nxt       = stk_cnt_r + PTR_W'(1);
            end
            rel_nxt = 1'b1;
          end else if (row_r.cnt == '0) begin
            w.nxt           = head_r[cls_r];
            w.prv           = NIL;
            head_nxt[cls_r] = {1'b0, frm_r};
            fa_en_nxt       = (head_r[cls_r] < NIL);
            fa_idx_nxt      = head_r[cls_r];
            fa_val_nxt      = {1'b0, frm_r};
          end
          fm_we      = 1'b1;
          fm_waddr   = frm_r;
          fm_wdata   = w;
          status_nxt = ST_OK;
          state_nxt  = S_FIX_ARD;
        end
      end
      S_FIX_ARD: begin
        if (fa_en_r) begin
          fm_raddr  = fa_idx_r[FRAME_W-1:0];
          state_nxt = S_FIX_AWR;
        end else begin
          state_nxt = S_FIX_BRD;
        end
      end
      S_FIX_AWR: begin
        w        = fm_rdata;
        w.prv    = fa_val_r;
        fm_we    = 1'b1;
        fm_waddr = fa_idx_r[FRAME_W-1:0];
        fm_wdata = w;
        state_nxt = S_FIX_BRD;
      end
      S_FIX_BRD: begin
        if (fb_en_r) begin
          fm_raddr  = fb_idx_r[FRAME_W-1:0];
          state_nxt = S_FIX_BWR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FIX_BWR: begin
        w        = fm_rdata;
        w.nxt    = fb_val_r;
        fm_we    = 1'b1;
        fm_waddr = fb_idx_r[FRAME_W-1:0];
        fm_wdata = w;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_grant_nxt  = grant_r;
          out_rel_nxt    = rel_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we && cfg_addr < CLS_W'(NREGS)) begin
      csize_nxt[cfg_addr] = cfg_data;
      dirty_nxt[cfg_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stk_cnt_r   <= PTR_W'(NUM_FRAMES);
      in_use_r    <= '0;
      stk_vld_r   <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
      fa_en_r     <= 1'b0;
      fb_en_r     <= 1'b0;
      for (int i = 0; i < NREGS; i++) begin
        csize_r[i] <= SIZE_RST[i];
        cap_r[i]   <= CAP_RST[i];
        head_r[i]  <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      stk_cnt_r   <= stk_cnt_nxt;
      in_use_r    <= in_use_nxt;
      stk_vld_r   <= stk_vld_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      fa_en_r     <= fa_en_nxt;
      fb_en_r     <= fb_en_nxt;
      csize_r     <= csize_nxt;
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
    end
    req_r        <= req_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    cls_r        <= cls_nxt;
    frm_r        <= frm_nxt;
    row_r        <= row_nxt;
    csz_r        <= csz_nxt;
    capv_r       <= capv_nxt;
    prod_r       <= prod_nxt;
    start_r      <= start_nxt;
    off_r        <= off_nxt;
    k_r          <= k_nxt;
    status_r     <= status_nxt;
    grant_r      <= grant_nxt;
    rel_r        <= rel_nxt;
    fa_idx_r     <= fa_idx_nxt;
    fa_val_r     <= fa_val_nxt;
    fb_idx_r     <= fb_idx_nxt;
    fb_val_r     <= fb_val_nxt;
    dcls_r       <= dcls_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_rel_r    <= out_rel_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'b0, out_rel_r, out_grant_r};

endmodule
